// ----- hw/rtl/sha_pkg.sv -----
// Shared types, round constants and initial hash values for the SHA-256 hasher.
`default_nettype none
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } sel_t;

  typedef struct packed {
    logic       shift;
    sel_t       sel;
    logic       load_v;
    logic       round;
    logic [5:0] rnd;
    logic       add;
    logic       clear;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } sts_t;

  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] RND_LAST  = 6'd63;
  localparam logic [2:0] IDX_LAST  = 3'd7;
  localparam logic [7:0] PAD_MARK  = 8'h80;

  localparam logic [31:0] HASH_IV [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage
`default_nettype wire

// ----- hw/rtl/sha_dp.sv -----
// SHA-256 datapath: message window, round variables, hash words and length.
`default_nettype none
module sha_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sha_pkg::cmd_t cmd,
  input  wire logic [7:0]    data_byte,
  output sha_pkg::sts_t      sts,
  output sha_pkg::out_t      out_data
);
  import sha_pkg::*;

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction
  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction
  function automatic logic [31:0] sml_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction
  function automatic logic [31:0] sml_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  logic [511:0] msg_r;
  logic [31:0]  hash_r [0:7];
  logic [31:0]  v_r    [0:7];
  logic [63:0]  bitlen_r;
  logic [5:0]   fill_r;

  logic [7:0]  byte_in;
  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] t1, t2, ch, maj;

  always_comb begin
    unique case (cmd.sel)
      SEL_DATA: byte_in = data_byte;
      SEL_MARK: byte_in = PAD_MARK;
      SEL_ZERO: byte_in = 8'h00;
      SEL_LEN:  byte_in = 8'(bitlen_r >> {~fill_r[2:0], 3'b000});
      default:  byte_in = 8'h00;
    endcase
  end

  // Window word k sits at msg_r[511-32k -: 32]; word 0 is the oldest.
  assign w0    = msg_r[511:480];
  assign w1    = msg_r[479:448];
  assign w9    = msg_r[223:192];
  assign w14   = msg_r[63:32];
  assign w_new = sml_s1(w14) + w9 + sml_s0(w1) + w0;

  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1  = v_r[7] + big_s1(v_r[4]) + ch + ROUND_K[cmd.rnd] + w0;
  assign t2  = big_s0(v_r[0]) + maj;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      bitlen_r <= '0;
      for (int i = 0; i < 8; i++) hash_r[i] <= HASH_IV[i];
    end else begin
      if (cmd.shift) begin
        msg_r  <= {msg_r[503:0], byte_in};
        fill_r <= fill_r + 6'd1;
        if (cmd.sel == SEL_DATA) bitlen_r <= bitlen_r + 64'd8;
      end
      if (cmd.load_v) begin
        for (int i = 0; i < 8; i++) v_r[i] <= hash_r[i];
      end
      if (cmd.round) begin
        msg_r  <= {msg_r[479:0], w_new};
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
      end
      if (cmd.add) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + v_r[i];
      end
      if (cmd.clear) begin
        bitlen_r <= '0;
        for (int i = 0; i < 8; i++) hash_r[i] <= HASH_IV[i];
      end
    end
  end

  assign sts.fill             = fill_r;
  assign out_data.digest_word = hash_r[cmd.idx];
  assign out_data.word_index  = cmd.idx;
  assign out_data.last_word   = (cmd.idx == IDX_LAST);

endmodule
`default_nettype wire

// ----- hw/rtl/sha_ctrl.sv -----
// SHA-256 controller: byte intake, padding sequence, round count and digest output.
`default_nettype none
module sha_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire sha_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire sha_pkg::sts_t sts,
  output sha_pkg::cmd_t      cmd
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       pad_r, pad_nxt;
  logic       mark_r, mark_nxt;
  logic       lenblk_r, lenblk_nxt;
  logic       fin_r, fin_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    idx_nxt       = idx_r;
    pad_nxt       = pad_r;
    mark_nxt      = mark_r;
    lenblk_nxt    = lenblk_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.sel       = SEL_DATA;
    cmd.rnd       = rnd_r;
    cmd.idx       = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.last) begin
            pad_nxt   = 1'b1;
            mark_nxt  = 1'b0;
            fin_nxt   = 1'b0;
            state_nxt = ST_PAD;
          end
          if (in_data.has_byte) begin
            cmd.shift = 1'b1;
            if (sts.fill == FILL_LAST) begin
              cmd.load_v = 1'b1;
              rnd_nxt    = '0;
              fin_nxt    = 1'b0;
              state_nxt  = ST_ROUND;
            end
          end
        end
      end
      ST_PAD: begin
        cmd.shift = 1'b1;
        if (!mark_r) begin
          cmd.sel    = SEL_MARK;
          mark_nxt   = 1'b1;
          lenblk_nxt = (sts.fill < LEN_POS);
        end else if (lenblk_r && sts.fill >= LEN_POS) begin
          cmd.sel = SEL_LEN;
        end else begin
          cmd.sel = SEL_ZERO;
        end
        if (sts.fill == FILL_LAST) begin
          cmd.load_v = 1'b1;
          rnd_nxt    = '0;
          fin_nxt    = mark_r && lenblk_r;
          state_nxt  = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == RND_LAST) state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (fin_r) begin
          idx_nxt       = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_OUT;
        end else if (pad_r) begin
          // the length always lands in the block after an overflow block
          lenblk_nxt = 1'b1;
          state_nxt  = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == IDX_LAST) begin
            cmd.clear     = 1'b1;
            out_valid_nxt = 1'b0;
            pad_nxt       = 1'b0;
            fin_nxt       = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      idx_r       <= '0;
      pad_r       <= 1'b0;
      mark_r      <= 1'b0;
      lenblk_r    <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      idx_r       <= idx_nxt;
      pad_r       <= pad_nxt;
      mark_r      <= mark_nxt;
      lenblk_r    <= lenblk_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> in_stall)
    else $error("input open while digest words pending");

  a_add_after_round63: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == RND_LAST) |=> (state_r == ST_ADD))
    else $error("compression did not finish after round 63");

  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(idx_r)))
    else $error("digest word index moved while stalled");

  a_fin_needs_pad: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> (pad_r && mark_r))
    else $error("final block flagged without padding");

endmodule
`default_nettype wire

// ----- hw/rtl/sha256_stream_hasher.sv -----
// SHA-256 stream hasher top level: controller plus datapath.
//
// Input channel (in_valid / in_stall / in_data): one message byte per beat.
// has_byte marks a real byte; last ends the message, and a beat with last and
// no byte finishes it without adding one (the empty message works this way).
// in_stall is high whenever the block is busy.
// Every 64th byte starts a compression: 64 rounds, one per cycle, on the
// single shared round unit, then a step that folds the round variables
// into the hash words; no further byte is taken until that step is done.
// On last, padding bytes shift in one per cycle (up to 64, or up to 72 when
// the length spills into an extra block), each full block compressed as above.
// Output channel (out_valid / out_stall / out_data): eight digest words,
// index 0 first, last_word on the eighth. Each word holds while out_stall is
// high; no input beat is taken until the eighth word is delivered, after which
// the hash words return to their initial values and the length clears.
// Reset: synchronous, active low; hash words take the initial values, byte
// count and bit length clear, both channels go idle.
`default_nettype none
module sha256_stream_hasher (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire sha_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output sha_pkg::out_t     out_data
);
  import sha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequence bytes, padding, rounds and digest beats
  sha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold the 512-bit window, round variables, hash words and bit length
  sha_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .data_byte (in_data.data_byte),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- bench/sha256_digest_checker.sv -----
// Digest predictor and scoreboard for the SHA-256 stream hasher.
module sha256_digest_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  sha_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  sha_pkg::out_t out_data,
  output int            fail_count,
  output int            pending_words
);
  import sha_pkg::*;

  logic [31:0] hash_state [0:7];
  logic [7:0]  msg_block [0:63];
  int unsigned block_fill;
  logic [63:0] msg_bits;
  out_t        digest_fifo [$];

  localparam logic [31:0] INIT_H [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [31:0] K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [0:63];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                                hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + K[t] + w[t];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic absorb_beat(input in_t beat);
    int unsigned pos;
    out_t word;
    if (beat.has_byte) begin
      msg_block[block_fill] = beat.data_byte;
      block_fill++;
      msg_bits += 64'd8;
      if (block_fill == 64) begin
        compress();
        block_fill = 0;
      end
    end
    if (!beat.last) return;
    pos = block_fill;
    msg_block[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      compress();
      pos = 0;
    end
    while (pos < 56) begin
      msg_block[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) msg_block[56+i] = msg_bits[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      word.digest_word = hash_state[i];
      word.word_index  = 3'(i);
      word.last_word   = (i == 7);
      digest_fifo.push_back(word);
    end
    hash_state = INIT_H;
    block_fill = 0;
    msg_bits = '0;
  endtask

  assign pending_words = digest_fifo.size();

  initial begin
    fail_count = 0;
    hash_state = INIT_H;
    block_fill = 0;
    msg_bits = '0;
  end

  always @(posedge clk) begin
    out_t exp_word;
    if (rst_n && in_valid && !in_stall) absorb_beat(in_data);
    if (rst_n && out_valid && !out_stall) begin
      if (digest_fifo.size() == 0) begin
        $error("unexpected digest beat %h", out_data);
        fail_count++;
      end else begin
        exp_word = digest_fifo.pop_front();
        if (out_data.digest_word !== exp_word.digest_word) begin
          $error("digest_word expected %h got %h", exp_word.digest_word, out_data.digest_word);
          fail_count++;
        end
        if (out_data.word_index !== exp_word.word_index) begin
          $error("word_index expected %0d got %0d", exp_word.word_index, out_data.word_index);
          fail_count++;
        end
        if (out_data.last_word !== exp_word.last_word) begin
          $error("last_word expected %0d got %0d", exp_word.last_word, out_data.last_word);
          fail_count++;
        end
      end
    end
  end
endmodule

// ----- bench/sha256_stream_hasher_tb.sv -----
// Stimulus and verdict for the SHA-256 stream hasher.
module sha256_stream_hasher_tb;
  import sha_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  int   fail_count;
  int   pending_words;
  int   beats_sent = 0;
  bit   quiet_tail = 1'b0;

  always #6 clk = ~clk;

  sha256_stream_hasher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  sha256_digest_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_words(pending_words)
  );

  // Present one beat at the falling edge, hold it until it is taken, then
  // maybe open a gap of random length before the next one.
  task automatic send_beat(input logic [7:0] b, input logic hb, input logic lst);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, has_byte: hb, last: lst};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Send a whole message of len random bytes; the tail beat may carry a byte
  // or be an empty final beat. Idle beats are sprinkled in now and then.
  task automatic send_message(input int len, input bit empty_tail);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, !empty_tail && i == len - 1);
    end
    if (empty_tail || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words != 0) @(posedge clk);
  endtask

  // Random receiver stalls in bursts; none during the quiet tail.
  initial begin
    forever begin
      @(negedge clk);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int len;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty message, idle beat, single extreme bytes, empty final beat.
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h55, 1'b1, 1'b0);
    send_beat(8'haa, 1'b1, 1'b0);
    send_beat(8'h12, 1'b0, 1'b1);
    // Hold off until every digest word has come back.
    drain();

    // Padding boundaries: 55 fits the length, 56 spills, 63 and 64 around a block.
    send_message(55, 1'b0);
    send_message(56, 1'b1);
    send_message(63, 1'b0);
    send_message(64, 1'b1);
    send_message(64, 1'b0);

    // Random messages, mostly short, a few long.
    while (beats_sent < 420) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
      send_message(len, $urandom_range(0, 1));
      if (beats_sent > 370) quiet_tail = 1'b1;
    end
    quiet_tail = 1'b1;
    send_message(3, 1'b0);
    drain();
    repeat (300) @(posedge clk);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/sha_pkg.sv
hw/rtl/sha_dp.sv
hw/rtl/sha_ctrl.sv
hw/rtl/sha256_stream_hasher.sv
bench/sha256_digest_checker.sv
bench/sha256_stream_hasher_tb.sv
